[hw/rtl/ucw_pkg.sv]
// Shared types, constants and width helpers for the UTF-8 line wrapper.
// Used by every module of the block; depends on nothing.
`default_nettype none

package ucw_pkg;

    // Input word: end-of-block flag and one raw text byte
    typedef struct packed {
        logic       req_type;
        logic [7:0] text_byte;
    } t_in_word;

    // Output word: one rendered byte and end-of-run marker
    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } t_out_word;

    // Request kinds
    localparam logic REQ_TEXT = 1'b0;
    localparam logic REQ_END  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_LINE_WIDTH   = 2'd0;
    localparam logic [1:0] CFG_PREFIX_LEN   = 2'd1;
    localparam logic [1:0] CFG_PREFIX_BYTES = 2'd2;

    localparam int unsigned CFG_DATA_W   = 40;
    localparam int unsigned PREFIX_BYTES = 5;
    localparam int unsigned POS_W        = 5;
    localparam int unsigned CMD_DEPTH    = 4;
    localparam int unsigned CMD_PTR_W    = 2;

    localparam logic [7:0]  ASCII_NL   = 8'h0A;
    localparam logic [7:0]  ASCII_TAB  = 8'h09;
    localparam logic [7:0]  ASCII_SP   = 8'h20;
    localparam logic [10:0] COLUMN_MAX = 11'h7FF;

    // Live configuration seen by front and back
    typedef struct packed {
        logic [9:0]            line_width;
        logic [2:0]            plen_eff;
        logic [CFG_DATA_W-1:0] prefix_bytes;
    } t_cfg;

    // One output burst: optional prefix, optional wrap, held bytes, newline
    typedef struct packed {
        logic            pre_prefix;
        logic            wrap;
        logic [2:0]      nbytes;
        logic [3:0][7:0] chars;
        logic            nl;
    } t_cmd;

    // Expected length of a character from its first byte
    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] n;
        if (b[7:5] == 3'b110) begin
            n = 3'd2;
        end else if (b[7:4] == 4'b1110) begin
            n = 3'd3;
        end else if (b[7:3] == 5'b11110) begin
            n = 3'd4;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

    // Width 2 for the East Asian wide ranges, else 1
    function automatic logic [1:0] wide_code(input logic [20:0] cp);
        logic hit;
        hit = (cp >= 21'h04E00 && cp <= 21'h09FFF) || (cp >= 21'h03400 && cp <= 21'h04DBF) ||
              (cp >= 21'h03000 && cp <= 21'h030FF) || (cp >= 21'h0FF00 && cp <= 21'h0FF60) ||
              (cp >= 21'h0FFE0 && cp <= 21'h0FFE6) || (cp >= 21'h0AC00 && cp <= 21'h0D7AF) ||
              (cp >= 21'h20000 && cp <= 21'h2A6DF) || (cp >= 21'h02E80 && cp <= 21'h02EFF) ||
              (cp >= 21'h02F00 && cp <= 21'h02FDF) || (cp >= 21'h0FE30 && cp <= 21'h0FE4F);
        return hit ? 2'd2 : 2'd1;
    endfunction

    // Display width of a held character; bytes not yet held count as zero
    function automatic logic [1:0] held_width(input logic [3:0][7:0] h,
                                              input logic [2:0] held,
                                              input logic [2:0] expected);
        logic [5:0]  k1;
        logic [5:0]  k2;
        logic [5:0]  k3;
        logic [20:0] cp;
        logic [1:0]  w;
        k1 = (held > 3'd1) ? h[1][5:0] : 6'd0;
        k2 = (held > 3'd2) ? h[2][5:0] : 6'd0;
        k3 = (held > 3'd3) ? h[3][5:0] : 6'd0;
        cp = '0;
        w  = 2'd1;
        if (!h[0][7]) begin
            if (h[0] == ASCII_TAB || h[0] == ASCII_NL) begin
                w = 2'd1;
            end else begin
                w = (h[0] < ASCII_SP) ? 2'd0 : 2'd1;
            end
        end else begin
            case (expected)
                3'd2: begin
                    cp = {10'd0, h[0][4:0], k1};
                    w  = wide_code(cp);
                end
                3'd3: begin
                    cp = {5'd0, h[0][3:0], k1, k2};
                    w  = wide_code(cp);
                end
                3'd4: begin
                    cp = {h[0][2:0], k1, k2, k3};
                    w  = wide_code(cp);
                end
                default: begin
                    w = 2'd1;
                end
            endcase
        end
        return w;
    endfunction

    // Prefix byte by position; bytes beyond the register read as zero
    function automatic logic [7:0] prefix_at(input logic [CFG_DATA_W-1:0] p,
                                             input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0: b = p[7:0];
            3'd1: b = p[15:8];
            3'd2: b = p[23:16];
            3'd3: b = p[31:24];
            3'd4: b = p[39:32];
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/ucw_front.sv]
// Front end: accepts input words, collects characters, tracks the column
// and issues at most one burst command per word. Depends on ucw_pkg.
`default_nettype none

module ucw_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire ucw_pkg::t_in_word i_word,
    input  wire ucw_pkg::t_cfg   i_cfg,
    output logic                 o_push,
    output ucw_pkg::t_cmd        o_cmd
);
    import ucw_pkg::*;

    logic [10:0]     r_column;
    logic [3:0][7:0] r_hold;
    logic [2:0]      r_held;
    logic [2:0]      r_expected;
    logic            r_pending;
    logic            r_started;

    logic [10:0]     n_column;
    logic [3:0][7:0] n_hold;
    logic [2:0]      n_held;
    logic [2:0]      n_expected;
    logic            n_pending;
    logic            n_started;

    logic [2:0]      held_c;
    logic [2:0]      exp_c;
    logic            pre;
    logic            place;
    logic            nl;
    logic [10:0]     col0;
    logic [10:0]     eff_col;
    logic [1:0]      w;
    logic            wrap;
    logic [11:0]     col_sum;
    logic [10:0]     col_sat;

    assign eff_col = {8'd0, i_cfg.plen_eff};

    // Classify the word and work out the burst and next state
    always_comb begin
        n_hold = r_hold;
        held_c = r_held;
        exp_c  = r_expected;
        pre    = 1'b0;
        place  = 1'b0;
        nl     = 1'b0;
        if (i_word.req_type == REQ_END) begin
            pre   = !r_started;
            place = (r_held != 3'd0);
            nl    = 1'b1;
        end else begin
            pre = !r_started || r_pending;
            if (r_held != 3'd0) begin
                n_hold[r_held[1:0]] = i_word.text_byte;
                held_c = r_held + 3'd1;
                place  = (held_c >= r_expected);
            end else if (i_word.text_byte == ASCII_NL) begin
                nl = 1'b1;
            end else begin
                n_hold[0] = i_word.text_byte;
                held_c    = 3'd1;
                exp_c     = lead_len(i_word.text_byte);
                place     = (exp_c == 3'd1);
            end
        end

        col0    = pre ? eff_col : r_column;
        w       = held_width(n_hold, held_c, exp_c);
        wrap    = place && (({1'b0, col0} + {10'd0, w}) > {2'd0, i_cfg.line_width})
                  && (col0 > eff_col);
        col_sum = {1'b0, (wrap ? eff_col : col0)} + {10'd0, w};
        col_sat = col_sum[11] ? COLUMN_MAX : col_sum[10:0];

        if (i_word.req_type == REQ_END) begin
            n_column   = 11'd0;
            n_held     = 3'd0;
            n_expected = 3'd0;
            n_pending  = 1'b0;
            n_started  = 1'b0;
        end else begin
            n_started  = 1'b1;
            n_pending  = nl;
            n_column   = nl ? 11'd0 : (place ? col_sat : col0);
            n_held     = place ? 3'd0 : held_c;
            n_expected = place ? 3'd0 : exp_c;
        end
    end

    // Issue a command only when the word produces output
    always_comb begin
        o_cmd.pre_prefix = pre;
        o_cmd.wrap       = wrap;
        o_cmd.nbytes     = place ? held_c : 3'd0;
        o_cmd.chars      = n_hold;
        o_cmd.nl         = nl;
        o_push = i_take && ((pre && i_cfg.plen_eff != 3'd0) || place || nl);
    end

    // Advance control state on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column   <= 11'd0;
            r_held     <= 3'd0;
            r_expected <= 3'd0;
            r_pending  <= 1'b0;
            r_started  <= 1'b0;
        end else if (i_take) begin
            r_column   <= n_column;
            r_held     <= n_held;
            r_expected <= n_expected;
            r_pending  <= n_pending;
            r_started  <= n_started;
        end
    end

    // Hold character bytes
    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_hold <= n_hold;
        end
    end

    a_held_below_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_held == 3'd0) || (r_held < r_expected))
        else $error("partial character count reached its length");

    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_word.req_type == REQ_END) |=>
        (r_held == 3'd0 && r_column == 11'd0 && !r_started && !r_pending))
        else $error("end of block left state behind");

    a_pending_at_line_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending |-> (r_column == 11'd0 && r_held == 3'd0))
        else $error("deferred prefix away from line start");

    a_no_double_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !(o_cmd.pre_prefix && o_cmd.wrap))
        else $error("wrap issued right after a prefix");

endmodule

`default_nettype wire

[hw/rtl/ucw_cmd_fifo.sv]
// Short command queue between front and back ends.
// Depends on ucw_pkg for the command type and depth.
`default_nettype none

module ucw_cmd_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ucw_pkg::t_cmd i_data,
    output logic               o_full,
    input  wire logic          i_pop,
    output ucw_pkg::t_cmd      o_data,
    output logic               o_empty
);
    import ucw_pkg::*;

    t_cmd               r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr;
    logic [CMD_PTR_W-1:0] r_rd;
    logic [CMD_PTR_W:0]   r_count;

    assign o_full  = (r_count == (CMD_PTR_W + 1)'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Store commands
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/ucw_back.sv]
// Back end: expands the head command into output words, one per cycle
// while the receiver is ready, through a registered output stage. Depends on ucw_pkg.
`default_nettype none

module ucw_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire ucw_pkg::t_cmd    i_cmd,
    input  wire logic             i_empty,
    input  wire ucw_pkg::t_cfg    i_cfg,
    output logic                  o_pop,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output ucw_pkg::t_out_word    o_word
);
    import ucw_pkg::*;

    logic [POS_W-1:0] r_pos;
    logic             r_valid;
    t_out_word        r_word;

    logic [POS_W-1:0] plen;
    logic [POS_W-1:0] seg_a;
    logic [POS_W-1:0] seg_b;
    logic [POS_W-1:0] seg_c;
    logic [POS_W-1:0] seg_d;
    logic [POS_W-1:0] seg_e;
    logic [POS_W-1:0] off_b;
    logic [POS_W-1:0] off_c;
    logic [7:0]       sel;
    logic             last;
    logic             load;

    // Segment bounds: prefix, wrap newline, wrap prefix, bytes, newline
    always_comb begin
        plen  = POS_W'(i_cfg.plen_eff);
        seg_a = i_cmd.pre_prefix ? plen : '0;
        seg_b = seg_a + POS_W'(i_cmd.wrap);
        seg_c = seg_b + (i_cmd.wrap ? plen : '0);
        seg_d = seg_c + POS_W'(i_cmd.nbytes);
        seg_e = seg_d + POS_W'(i_cmd.nl);
        off_b = r_pos - seg_b;
        off_c = r_pos - seg_c;
        if (r_pos < seg_a) begin
            sel = prefix_at(i_cfg.prefix_bytes, r_pos[2:0]);
        end else if (r_pos < seg_b) begin
            sel = ASCII_NL;
        end else if (r_pos < seg_c) begin
            sel = prefix_at(i_cfg.prefix_bytes, off_b[2:0]);
        end else if (r_pos < seg_d) begin
            sel = i_cmd.chars[off_c[1:0]];
        end else begin
            sel = ASCII_NL;
        end
        last  = (r_pos == seg_e - 1'b1);
        load  = !i_empty && (!r_valid || i_ready);
        o_pop = load && last;
    end

    // Load the output stage and step through the burst
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= last ? '0 : r_pos + 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // Hold the output word
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_word.out_byte    <= sel;
            r_word.last_of_run <= last;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

`default_nettype wire

[hw/rtl/utf8_cjk_width_line_wrapper.sv]
// Top level of the UTF-8 line wrapper: configuration registers, front end,
// command queue and back end. Depends on ucw_pkg, ucw_front, ucw_cmd_fifo, ucw_back.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_word) takes one word per
//   cycle: a text byte, or the end-of-block marker. Output channel
//   (o_out_valid / i_out_ready / o_out_word) gives the rendered bytes; the
//   last byte caused by an input word carries last_of_run.
//   A word that only starts or extends a multi-byte character produces no
//   output beyond a due line prefix. Others give one burst of up to
//   PREFIX_MAX + 5 bytes. The command of an accepted word is written into
//   the command queue and then loaded into the output register.
//   Throughput: one input word per cycle while the queue has room and one
//   output byte per cycle while the receiver is ready; the single output
//   register sets the byte rate, so bursts longer than one byte fill the
//   four-entry command queue and then hold off input.
//   When the receiver stalls, the output byte holds and the queue fills;
//   o_in_ready drops only when the queue is full.
//   Reset (synchronous, active low) clears the column, character and block
//   state and loads line_width 80 with an empty prefix.
//   Configuration writes (i_cfg_we) take effect on the next edge; the user
//   must make them only while the block is idle; the block does not enforce it.
`default_nettype none

module utf8_cjk_width_line_wrapper #(
    parameter int unsigned PREFIX_MAX = 5
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire ucw_pkg::t_in_word            i_in_word,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output ucw_pkg::t_out_word                o_out_word,
    input  wire logic                         i_cfg_we,
    input  wire logic [1:0]                   i_cfg_index,
    input  wire logic [ucw_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ucw_pkg::*;

    logic [9:0]            r_line_width;
    logic [2:0]            r_prefix_len;
    logic [CFG_DATA_W-1:0] r_prefix_bytes;

    t_cfg  cfg;
    t_cmd  push_cmd;
    t_cmd  head_cmd;
    logic  push;
    logic  pop;
    logic  full;
    logic  empty;
    logic  take;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= 10'd80;
            r_prefix_len   <= 3'd0;
            r_prefix_bytes <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LINE_WIDTH:   r_line_width   <= i_cfg_data[9:0];
                CFG_PREFIX_LEN:   r_prefix_len   <= i_cfg_data[2:0];
                CFG_PREFIX_BYTES: r_prefix_bytes <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Clamp the prefix length
    always_comb begin
        cfg.line_width   = r_line_width;
        cfg.prefix_bytes = r_prefix_bytes;
        if ({1'b0, r_prefix_len} > 4'(PREFIX_MAX)) begin
            cfg.plen_eff = 3'(PREFIX_MAX);
        end else begin
            cfg.plen_eff = r_prefix_len;
        end
    end

    assign o_in_ready = !full;
    assign take       = i_in_valid && o_in_ready;

    ucw_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_word  (i_in_word),
        .i_cfg   (cfg),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    ucw_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_empty (empty)
    );

    ucw_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (head_cmd),
        .i_empty (empty),
        .i_cfg   (cfg),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_word  (o_out_word)
    );

endmodule

`default_nettype wire
